>>> hdl/tdpb_pkg.sv
// Shared types, sizes and helpers for the tail-drop packet buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tdpb_pkg;

  // Depth of the finish-time store and the widths that follow from it.
  localparam int MAX_DEPTH = 64;
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W     = 7;
  localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int TIME_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_DEPTH);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;   // capture the input beat
    logic pop;     // retire the oldest entry
    logic finish;  // decide drop or push and load the result register
  } tdpb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_retire;  // oldest entry finishes at or before the arrival
  } tdpb_stat_t;

  // Circular increment of a store index.
  function automatic idx_t next_idx(input idx_t i);
    idx_t r;
    if (i == LAST_IDX) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tdpb_ctrl.sv
// Controller state machine for the tail-drop packet buffer.
// Depends on tdpb_pkg for the command and status structs.
`default_nettype none

module tdpb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tdpb_pkg::tdpb_stat_t stat,
  output tdpb_pkg::tdpb_cmd_t     cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RETIRE = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic room;

  // The result register is free when empty or being emptied this cycle.
  assign room     = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next-state and command decode.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (stat.can_retire) begin
          cmd.pop = 1'b1;
        end else if (room) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tdpb_dp.sv
// Datapath of the tail-drop packet buffer: finish-time store, pointers,
// occupancy, capacity register and result register. Depends on tdpb_pkg.
`default_nettype none

module tdpb_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [tdpb_pkg::CAP_W-1:0] cfg_data,
  input  wire tdpb_pkg::time_t            pkt_arrival,
  input  wire tdpb_pkg::time_t            pkt_duration,
  input  wire tdpb_pkg::tdpb_cmd_t        cmd,
  output tdpb_pkg::tdpb_stat_t            stat,
  output logic                            dropped,
  output tdpb_pkg::time_t                 pkt_start
);

  tdpb_pkg::time_t finish_mem [tdpb_pkg::MAX_DEPTH];

  logic [tdpb_pkg::CAP_W-1:0] capacity;
  tdpb_pkg::idx_t  head;
  tdpb_pkg::idx_t  tail;
  tdpb_pkg::cnt_t  occupancy;
  tdpb_pkg::time_t newest_finish;
  tdpb_pkg::time_t arrival;
  tdpb_pkg::time_t proc;
  tdpb_pkg::time_t head_finish;

  tdpb_pkg::idx_t  head_next;
  tdpb_pkg::time_t start;
  logic [tdpb_pkg::TIME_W:0] sum;
  tdpb_pkg::time_t finish;
  logic            full;
  logic            push;

  // Retire test against the registered head entry.
  assign stat.can_retire = (occupancy != '0) && (head_finish <= arrival);

  // Occupancy at or above the configured capacity, or at the store depth.
  assign full = (tdpb_pkg::CMP_W'(occupancy) >= tdpb_pkg::CMP_W'(capacity)) ||
                (occupancy == tdpb_pkg::FULL_CNT);

  // Start time and saturating finish time of the held packet.
  assign start  = (occupancy == '0) ? arrival : newest_finish;
  assign sum    = {1'b0, start} + {1'b0, proc};
  assign finish = sum[tdpb_pkg::TIME_W] ? '1 : sum[tdpb_pkg::TIME_W-1:0];
  assign push   = cmd.finish && !full;

  assign head_next = cmd.pop ? tdpb_pkg::next_idx(head) : head;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= tdpb_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Pointers, occupancy and newest finish time.
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      occupancy     <= '0;
      newest_finish <= '0;
    end else begin
      head <= head_next;
      if (cmd.pop) begin
        occupancy <= occupancy - tdpb_pkg::cnt_t'(1);
      end else if (push) begin
        occupancy <= occupancy + tdpb_pkg::cnt_t'(1);
      end
      if (push) begin
        tail          <= tdpb_pkg::next_idx(tail);
        newest_finish <= finish;
      end
    end
  end

  // Captured input beat.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      arrival <= pkt_arrival;
      proc    <= pkt_duration;
    end
  end

  // Finish-time store: one write port, one registered read of the next head,
  // with the written value forwarded when both name the same entry.
  always_ff @(posedge clk) begin
    if (push) begin
      finish_mem[tail] <= finish;
    end
    if (push && (tail == head_next)) begin
      head_finish <= finish;
    end else begin
      head_finish <= finish_mem[head_next];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dropped   <= full;
      pkt_start <= full ? '0 : start;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tail_drop_packet_buffer_unit.sv
// Tail-drop packet buffer, top level: controller plus datapath.
// The input beat is captured, finished entries are retired, then the packet
// is dropped or pushed and the result register loaded, where it waits for
// the sink. A new packet is taken only after the last is decided. Each entry
// is retired once, one per cycle, through the store's single read port.
// Reset (synchronous): empty buffer, capacity 64, no result pending.
`default_nettype none

module tail_drop_packet_buffer_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [tdpb_pkg::CAP_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [31:0]                pkt_arrival,
  input  wire logic [31:0]                pkt_duration,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            dropped,
  output logic [31:0]                     pkt_start
);

  tdpb_pkg::tdpb_cmd_t  cmd;
  tdpb_pkg::tdpb_stat_t stat;

  // Sequencing of retire and decide steps.
  tdpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, counters and result register.
  tdpb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .pkt_arrival  (pkt_arrival),
    .pkt_duration (pkt_duration),
    .cmd          (cmd),
    .stat         (stat),
    .dropped      (dropped),
    .pkt_start    (pkt_start)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the tail-drop packet buffer (tail_drop_packet_buffer_unit).
// A queue-fed driver and a monitor check every result against an in-bench FIFO predictor.
// Depends on tdpb_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 2 * tdpb_pkg::MAX_DEPTH + 8;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PACKETS = 37;

  typedef struct {
    tdpb_pkg::time_t arrival;
    tdpb_pkg::time_t dur;
  } packet_t;

  typedef struct {
    logic            dropped;
    tdpb_pkg::time_t start;
  } verdict_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [tdpb_pkg::CAP_W-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [31:0]                pkt_arrival;
  logic [31:0]                pkt_duration;
  logic                       out_valid;
  logic                       out_ready;
  logic                       dropped;
  logic [31:0]                pkt_start;

  // Stimulus and scoreboard state.
  packet_t         pkt_queue[$];
  verdict_t        verdicts[$];
  int              packets_issued = 0;
  int              packets_taken  = 0;
  int              drops_seen     = 0;
  int              admits_seen    = 0;
  int              settings_used  = 0;
  int              errors         = 0;
  int              cycles         = 0;
  int              src_gap        = 0;
  int              sink_stall     = 0;
  bit              idle_on        = 1'b1;
  bit              beat_taken     = 1'b0;
  tdpb_pkg::time_t arrival_now    = '0;

  // Predictor state: a FIFO of finish times plus the capacity register.
  tdpb_pkg::time_t            finish_q [tdpb_pkg::MAX_DEPTH];
  tdpb_pkg::idx_t             oldest_slot = '0;
  tdpb_pkg::idx_t             free_slot   = '0;
  tdpb_pkg::cnt_t             held        = '0;
  tdpb_pkg::time_t            last_finish = '0;
  logic [tdpb_pkg::CAP_W-1:0] cap_model   = tdpb_pkg::CAP_RESET;

  tail_drop_packet_buffer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pkt_arrival  (pkt_arrival),
    .pkt_duration (pkt_duration),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dropped      (dropped),
    .pkt_start    (pkt_start)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Retire finished entries, then either drop the packet or push its finish time.
  function automatic void admit_packet(input tdpb_pkg::time_t arr,
                                       input tdpb_pkg::time_t dur);
    verdict_t                   v;
    logic [32:0]                sum;
    logic [tdpb_pkg::CAP_W-1:0] limit;
    while (held != 0 && finish_q[oldest_slot] <= arr) begin
      oldest_slot = (oldest_slot == tdpb_pkg::idx_t'(tdpb_pkg::MAX_DEPTH - 1)) ? '0
                                                                   : oldest_slot + 1'b1;
      held        = held - 1'b1;
    end
    limit = (cap_model > tdpb_pkg::MAX_DEPTH) ? tdpb_pkg::CAP_W'(tdpb_pkg::MAX_DEPTH)
                                              : cap_model;
    if (held >= limit) begin
      v.dropped = 1'b1;
      v.start   = '0;
    end else begin
      v.dropped    = 1'b0;
      v.start      = (held == 0) ? arr : last_finish;
      sum          = {1'b0, v.start} + {1'b0, dur};
      last_finish  = sum[32] ? '1 : sum[31:0];
      finish_q[free_slot] = last_finish;
      free_slot    = (free_slot == tdpb_pkg::idx_t'(tdpb_pkg::MAX_DEPTH - 1)) ? '0
                                                                 : free_slot + 1'b1;
      held         = held + 1'b1;
    end
    verdicts.insert(verdicts.size(), v);
  endfunction

  task automatic queue_packet(input tdpb_pkg::time_t arr, input tdpb_pkg::time_t dur);
    packet_t p;
    p.arrival = arr;
    p.dur     = dur;
    pkt_queue.insert(pkt_queue.size(), p);
    packets_issued++;
  endtask

  // Wait until every packet has been taken and every result checked.
  task automatic settle();
    while (pkt_queue.size() != 0 || packets_taken != packets_issued || verdicts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called while the unit is idle.
  task automatic write_capacity(input logic [tdpb_pkg::CAP_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_model = value;
    settings_used++;
  endtask

  // With capacity zero a packet at the latest possible arrival retires everything
  // and is itself dropped, which leaves the buffer empty.
  task automatic flush_buffer();
    write_capacity('0);
    queue_packet('1, tdpb_pkg::time_t'($urandom));
    settle();
  endtask

  // Mostly non-decreasing arrivals with a load close to the service rate, so the
  // buffer fills and drains; rare jumps, reversals and very long packets.
  task automatic queue_random_packets(input int count);
    int              roll;
    tdpb_pkg::time_t dur;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 39);
      if (roll < 30) begin
        arrival_now += $urandom_range(0, 6);
      end else if (roll < 35) begin
        arrival_now += $urandom_range(9, 60);
      end else if (roll < 36) begin
        arrival_now += $urandom_range(0, 1 << 20);
      end else if (roll < 38) begin
        arrival_now = arrival_now;
      end else if (roll < 39) begin
        arrival_now -= $urandom_range(1, 64);
      end else begin
        arrival_now = $urandom;
      end
      roll = $urandom_range(0, 79);
      if (roll == 0) begin
        dur = $urandom;
      end else if (roll < 6) begin
        dur = $urandom_range(15, 5000);
      end else begin
        dur = $urandom_range(0, 14);
      end
      queue_packet(arrival_now, dur);
    end
  endtask

  // Driver: a new beat is offered at the falling edge once the last one was taken.
  always @(negedge clk) begin : drive_packets
    packet_t nxt;
    if (rst !== 1'b0) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !beat_taken)) begin
      beat_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pkt_queue.size() != 0 && !(idle_on && $urandom_range(0, 6) == 0)) begin
        nxt = pkt_queue.pop_front();
        pkt_arrival  <= nxt.arrival;
        pkt_duration <= nxt.dur;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (idle_on && pkt_queue.size() != 0) begin
          src_gap = $urandom_range(0, 4);
        end
      end
    end
  end

  // Result side back-pressure in short random bursts.
  always @(negedge clk) begin
    if (rst !== 1'b0) begin
      out_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each input beat, check each result beat, watch the clock.
  always @(posedge clk) begin : monitor
    verdict_t exp_v;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles,
               verdicts.size());
      $display("FAIL");
      $finish;
    end
    if (rst === 1'b0 && in_valid && in_ready) begin
      admit_packet(pkt_arrival, pkt_duration);
      packets_taken++;
      beat_taken = 1'b1;
    end
    if (rst === 1'b0 && out_valid && out_ready) begin
      if (verdicts.size() == 0) begin
        $error("Result beat with no packet outstanding");
        errors++;
      end else begin
        exp_v = verdicts.pop_front();
        if (exp_v.dropped) drops_seen++;
        else admits_seen++;
        if (dropped !== exp_v.dropped) begin
          $error("dropped: expected %0b, got %0b", exp_v.dropped, dropped);
          errors++;
        end
        if (pkt_start !== exp_v.start) begin
          $error("pkt_start: expected %0h, got %0h", exp_v.start, pkt_start);
          errors++;
        end
      end
    end
  end

  // Sequence of phases.
  initial begin : run
    logic [tdpb_pkg::CAP_W-1:0] cap;
    logic [tdpb_pkg::CAP_W-1:0] extremes [4];
    extremes     = '{tdpb_pkg::CAP_W'(1), tdpb_pkg::CAP_W'(64), tdpb_pkg::CAP_W'(127),
                     tdpb_pkg::CAP_W'(2)};
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    pkt_arrival  = '0;
    pkt_duration = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: zero-length packets, back-to-back starts, saturation at the
    // top of the time range and an arrival that goes backwards.
    queue_packet(32'h0000_0000, 32'h0000_0000);
    queue_packet(32'h0000_0000, 32'h0000_0005);
    queue_packet(32'h0000_0001, 32'h0000_0003);
    queue_packet(32'h0000_0002, 32'hFFFF_FFFF);
    queue_packet(32'hFFFF_FFFF, 32'h0000_0000);
    queue_packet(32'h0000_0005, 32'h0000_0001);
    settle();

    // Capacity zero drops everything, even with entries still held.
    write_capacity('0);
    queue_packet(32'h8000_0000, 32'h0000_0009);
    queue_packet(32'hFFFF_FFFF, 32'h0000_0001);
    settle();

    // Capacity above the store depth is clamped.
    write_capacity(tdpb_pkg::CAP_W'(127));
    queue_packet(32'h0000_0064, 32'h5555_5555);
    queue_packet(32'h0000_0064, 32'hAAAA_AAAA);
    queue_packet(32'h0000_0065, 32'h0000_0001);
    settle();

    // Capacity lowered below the number of entries held.
    write_capacity(tdpb_pkg::CAP_W'(2));
    queue_packet(32'h0000_0066, 32'h0000_0004);
    queue_packet(32'hFFFF_FFFE, 32'h0000_0000);
    settle();

    write_capacity(tdpb_pkg::CAP_W'(64));
    queue_packet(32'hFFFF_FFFF, 32'h0000_0000);
    settle();

    // Random phases; the last one runs without idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
      if (p < 4 || $urandom_range(0, 1) == 1) begin
        flush_buffer();
        arrival_now = ($urandom_range(0, 2) == 0) ? tdpb_pkg::time_t'($urandom)
                                                  : tdpb_pkg::time_t'($urandom_range(0, 1000));
      end
      if (p < 4) begin
        cap = extremes[p];
      end else if ($urandom_range(0, 5) == 0) begin
        cap = tdpb_pkg::CAP_W'($urandom_range(65, 127));
      end else begin
        cap = tdpb_pkg::CAP_W'($urandom_range(1, 64));
      end
      write_capacity(cap);
      queue_random_packets(PHASE_PACKETS);
      settle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (verdicts.size() != 0) begin
      $error("%0d results never arrived", verdicts.size());
      errors++;
    end
    $display("Covered %0d packets over %0d capacity writes: %0d admitted, %0d dropped.",
             packets_taken, settings_used, admits_seen, drops_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> tail_drop_packet_buffer_unit.f
hdl/tdpb_pkg.sv
hdl/tdpb_ctrl.sv
hdl/tdpb_dp.sv
hdl/tail_drop_packet_buffer_unit.sv
tb/sv/testbench.sv
